### hdl/start_char_crlf_frame_receiver_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef START_CHAR_CRLF_FRAME_RECEIVER_UNIT_MACROS_SVH
`define START_CHAR_CRLF_FRAME_RECEIVER_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define SCFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// Check a consequence in the cycle after its antecedent.
`define SCFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

### hdl/scfr_pkg.sv
package scfr_pkg;

    // Payload buffer depth and the width of a count that can hold it
    localparam int BUFFER_DEPTH = 64;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

    // Line control characters
    localparam logic [7:0] CODE_CR = 8'h0D;
    localparam logic [7:0] CODE_LF = 8'h0A;

    // Receive phase
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_RECV     = 2'd1,
        PH_AFTER_CR = 2'd2
    } phase_t;

    // One byte held in the input stage
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } scfr_item_t;

endpackage

### hdl/scfr_in_stage.sv
module scfr_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  logic                take,
    output scfr_pkg::scfr_item_t item
);
    import scfr_pkg::*;

    logic       vld_reg;
    logic [7:0] byte_reg;

    // Accept a new byte when empty or when the held byte moves on
    assign in_ready = !vld_reg || take;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    // Capture the byte on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign item.valid   = vld_reg;
    assign item.rx_byte = byte_reg;

endmodule

### hdl/scfr_core.sv
module scfr_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scfr_pkg::scfr_item_t item,
    output logic                 take,
    input  logic [7:0]           start_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 store_valid,
    output logic [5:0]           store_index,
    output logic [7:0]           store_byte,
    output logic                 frame_done,
    output logic [6:0]           frame_length,
    output logic                 frame_dropped,
    output logic                 frame_ready
);
    import scfr_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rdy_reg, rdy_next;

    logic             hit_open, hit_cr, hit_lf, hit_store, hit_drop;
    logic             step;
    logic [CNT_W+6:0] cnt_wide;

    logic             out_valid_reg;
    logic             store_valid_reg;
    logic [5:0]       store_index_reg;
    logic [7:0]       store_byte_reg;
    logic             frame_done_reg;
    logic [6:0]       frame_length_reg;
    logic             frame_dropped_reg;
    logic             frame_ready_reg;

    // Move a byte into the result register when it is free or being drained
    assign take = !out_valid_reg || out_ready;
    assign step = item.valid && take;

    // Decode what this byte does in the current phase
    always_comb
    begin
        hit_open  = 1'b0;
        hit_cr    = 1'b0;
        hit_lf    = 1'b0;
        hit_store = 1'b0;
        hit_drop  = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                hit_open = (item.rx_byte == start_byte);
            end
            PH_RECV:
            begin
                if (item.rx_byte == CODE_CR)
                begin
                    hit_cr = 1'b1;
                end
                else if (item.rx_byte == CODE_LF)
                begin
                    hit_lf = 1'b1;
                end
                else if (cnt_reg >= CNT_W'(BUFFER_DEPTH))
                begin
                    hit_drop = 1'b1;
                end
                else
                begin
                    hit_store = 1'b1;
                end
            end
            PH_AFTER_CR:
            begin
                if (item.rx_byte == CODE_CR)
                begin
                    hit_cr = 1'b1;
                end
                else if (item.rx_byte == CODE_LF)
                begin
                    hit_lf = 1'b1;
                end
                else
                begin
                    hit_drop = 1'b1;
                end
            end
            default:
            begin
                hit_cr = (item.rx_byte == CODE_CR);
                hit_lf = (item.rx_byte == CODE_LF);
            end
        endcase
    end

    // Next phase, count and ready flag
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        rdy_next   = rdy_reg;
        if (hit_open)
        begin
            phase_next = PH_RECV;
            cnt_next   = '0;
        end
        else if (hit_cr)
        begin
            phase_next = PH_AFTER_CR;
        end
        else if (hit_lf)
        begin
            phase_next = PH_IDLE;
            rdy_next   = 1'b1;
        end
        else if (hit_store)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (hit_drop)
        begin
            phase_next = PH_IDLE;
            cnt_next   = '0;
            rdy_next   = 1'b0;
        end
    end

    // Hold frame state, advance on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            rdy_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            rdy_reg   <= rdy_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= item.valid;
        end
    end

    // Zero-extended count; its low bits give the index field
    assign cnt_wide = {7'd0, cnt_reg};

    // Load the result fields
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            store_valid_reg   <= hit_store;
            store_index_reg   <= hit_store ? cnt_wide[5:0] : 6'd0;
            store_byte_reg    <= hit_store ? item.rx_byte : 8'd0;
            frame_done_reg    <= hit_lf;
            frame_length_reg  <= 7'(cnt_next);
            frame_dropped_reg <= hit_drop;
            frame_ready_reg   <= rdy_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign store_valid   = store_valid_reg;
    assign store_index   = store_index_reg;
    assign store_byte    = store_byte_reg;
    assign frame_done    = frame_done_reg;
    assign frame_length  = frame_length_reg;
    assign frame_dropped = frame_dropped_reg;
    assign frame_ready   = frame_ready_reg;

endmodule

### hdl/start_char_crlf_frame_receiver_unit.sv
// Start-delimited, CR/LF-terminated frame receiver.
// Input channel: in_valid / in_ready with rx_byte, one received serial byte
// per transfer. Output channel: out_valid / out_ready, one result per byte,
// carrying the buffer write (store_valid, store_index, store_byte) and the
// frame status (frame_done, frame_length, frame_dropped, frame_ready).
// Configuration channel: cfg_valid / cfg_ready with cfg_data, the start byte;
// cfg_ready is always high, write only while the block is idle.
// Each accepted byte is held in the input register, then loaded into the result
// register, where its result stays until taken. One byte per cycle while out_ready
// is high; the phase/count update between the two registers is combinational.
// Reset clears the phase to idle, the count, the ready flag, the start byte
// and both stage valids. When the receiver holds out_ready low, the result
// stays put, the input register fills, and in_ready drops until the result
// is taken; no byte is lost.
module start_char_crlf_frame_receiver_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       store_valid,
    output logic [5:0] store_index,
    output logic [7:0] store_byte,
    output logic       frame_done,
    output logic [6:0] frame_length,
    output logic       frame_dropped,
    output logic       frame_ready
);
    import scfr_pkg::*;

    scfr_item_t item;
    logic       take;
    logic [7:0] start_byte_reg;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            start_byte_reg <= cfg_data;
        end
    end

    scfr_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .take     (take),
        .item     (item)
    );

    scfr_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .take          (take),
        .start_byte    (start_byte_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .store_valid   (store_valid),
        .store_index   (store_index),
        .store_byte    (store_byte),
        .frame_done    (frame_done),
        .frame_length  (frame_length),
        .frame_dropped (frame_dropped),
        .frame_ready   (frame_ready)
    );

endmodule

### hdl/scfr_checker.sv
`include "start_char_crlf_frame_receiver_unit_macros.svh"

module scfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] rx_byte,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic [7:0] cfg_data,
    input logic       out_valid,
    input logic       out_ready,
    input logic       store_valid,
    input logic [5:0] store_index,
    input logic [7:0] store_byte,
    input logic       frame_done,
    input logic [6:0] frame_length,
    input logic       frame_dropped,
    input logic       frame_ready
);

    // A stalled result holds its status
    `SCFR_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(frame_length) && $stable(frame_ready))

    // A stored byte neither ends nor aborts the frame
    `SCFR_ASSERT_NOW(a_store_excl, out_valid && store_valid, !frame_done && !frame_dropped)

    // A stored byte leaves the length one past its index
    `SCFR_ASSERT_NOW(a_store_len, out_valid && store_valid, frame_length == ({1'b0, store_index} + 7'd1))

    // An abort empties the frame and clears ready
    `SCFR_ASSERT_NOW(a_drop_clear, out_valid && frame_dropped, frame_length == 7'd0 && !frame_ready && !frame_done)

    // A completed frame raises ready
    `SCFR_ASSERT_NOW(a_done_ready, out_valid && frame_done, frame_ready)

endmodule

bind start_char_crlf_frame_receiver_unit scfr_checker u_scfr_checker (.*);

### test/tb_start_char_crlf_frame_receiver_unit.sv
`timescale 1ns / 100ps

module tb_start_char_crlf_frame_receiver_unit;

    import scfr_pkg::*;

    localparam int DIR_N          = 18;
    localparam int PHASE_COUNT    = 7;
    localparam int PHASE_BYTES    = 135;
    localparam int WATCHDOG_LIMIT = 400;

    // One result as the block reports it for one received byte
    typedef struct packed {
        logic       st_valid;
        logic [5:0] st_index;
        logic [7:0] st_byte;
        logic       done;
        logic [6:0] length;
        logic       dropped;
        logic       ready;
    } frame_status_t;

    // One byte to send, with an optional hand-written expectation
    typedef struct packed {
        logic [7:0]    rx;
        logic          fixed;
        frame_status_t status;
    } rx_job_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       store_valid;
    logic [5:0] store_index;
    logic [7:0] store_byte;
    logic       frame_done;
    logic [6:0] frame_length;
    logic       frame_dropped;
    logic       frame_ready;

    // Predictor state
    phase_t     mdl_phase = PH_IDLE;
    logic [6:0] mdl_count = '0;
    logic       mdl_ready = 1'b0;
    logic [7:0] mdl_start = 8'h00;

    rx_job_t       byte_jobs[$];
    frame_status_t status_q[$];
    rx_job_t       dir_tbl[DIR_N];
    rx_job_t       cur_job;

    bit calm = 1'b0;
    int mismatch_count = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int long_stall = 0;
    logic [15:0] stall_mask = 16'hFFFF;
    logic [3:0]  mask_pos = 4'd0;

    start_char_crlf_frame_receiver_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .store_valid   (store_valid),
        .store_index   (store_index),
        .store_byte    (store_byte),
        .frame_done    (frame_done),
        .frame_length  (frame_length),
        .frame_dropped (frame_dropped),
        .frame_ready   (frame_ready)
    );

    always #5 clk = ~clk;

    // Advance the frame state by one received byte and return its status
    function automatic frame_status_t rx_byte_outcome(input logic [7:0] b);
        frame_status_t s;
        s = '0;
        if (mdl_phase == PH_IDLE)
        begin
            if (b == mdl_start)
            begin
                mdl_phase = PH_RECV;
                mdl_count = '0;
            end
        end
        else if (b == CODE_CR)
        begin
            mdl_phase = PH_AFTER_CR;
        end
        else if (b == CODE_LF)
        begin
            mdl_phase = PH_IDLE;
            mdl_ready = 1'b1;
            s.done    = 1'b1;
        end
        else if (mdl_phase == PH_RECV)
        begin
            if (mdl_count >= 7'(BUFFER_DEPTH))
            begin
                mdl_phase = PH_IDLE;
                mdl_ready = 1'b0;
                mdl_count = '0;
                s.dropped = 1'b1;
            end
            else
            begin
                s.st_valid = 1'b1;
                s.st_index = mdl_count[5:0];
                s.st_byte  = b;
                mdl_count  = mdl_count + 7'd1;
            end
        end
        else
        begin
            // bad byte after CR
            mdl_phase = PH_IDLE;
            mdl_ready = 1'b0;
            mdl_count = '0;
            s.dropped = 1'b1;
        end
        s.length = mdl_count;
        s.ready  = mdl_ready;
        return s;
    endfunction

    function automatic frame_status_t status_of(input logic sv, input logic [5:0] idx,
                                                input logic [7:0] sb, input logic dn,
                                                input logic [6:0] len, input logic dr,
                                                input logic rdy);
        frame_status_t s;
        s = '{st_valid: sv, st_index: idx, st_byte: sb, done: dn,
              length: len, dropped: dr, ready: rdy};
        return s;
    endfunction

    function automatic rx_job_t dir_row(input logic [7:0] b, input logic fixed,
                                        input frame_status_t s);
        rx_job_t j;
        j.rx     = b;
        j.fixed  = fixed;
        j.status = s;
        return j;
    endfunction

    function automatic string status_str(input frame_status_t s);
        return $sformatf("sv=%0b idx=%0d byte=%02h done=%0b len=%0d drop=%0b rdy=%0b",
                         s.st_valid, s.st_index, s.st_byte, s.done, s.length,
                         s.dropped, s.ready);
    endfunction

    // Send bytes in bursts; predict each one at its transfer
    always @(posedge clk or negedge rst_n)
    begin : drive_in
        logic       nv;
        logic [7:0] nb;
        frame_status_t pred;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            rx_byte    <= 8'h00;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            nv = 1'b0;
            nb = rx_byte;
            if (in_valid)
            begin
                pred = rx_byte_outcome(rx_byte);
                status_q.push_back(cur_job.fixed ? cur_job.status : pred);
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 12);
                    if (calm || $urandom_range(0, 2) == 0)
                        gap_left = 0;
                    else
                        gap_left = $urandom_range(1, 8);
                end
            end
            if (gap_left != 0)
                gap_left--;
            else if (byte_jobs.size() != 0)
            begin
                cur_job = byte_jobs.pop_front();
                nv      = 1'b1;
                nb      = cur_job.rx;
            end
            in_valid <= nv;
            rx_byte  <= nb;
        end
    end

    // Stall the result channel on a rotating mask, with an occasional long hold
    always @(posedge clk or negedge rst_n)
    begin : stall_out
        logic rdy;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            long_stall = 0;
            mask_pos   = 4'd0;
        end
        else
        begin
            if (calm)
                rdy = 1'b1;
            else if (long_stall != 0)
            begin
                long_stall--;
                rdy = 1'b0;
            end
            else
            begin
                if (mask_pos == 4'd0)
                begin
                    case ($urandom_range(0, 3))
                        0:       stall_mask = 16'hFFFF;
                        1:       stall_mask = 16'($urandom);
                        2:       stall_mask = 16'($urandom | $urandom);
                        default: stall_mask = 16'($urandom & $urandom);
                    endcase
                    if ($urandom_range(0, 15) == 0)
                        long_stall = $urandom_range(10, 24);
                end
                rdy      = stall_mask[mask_pos];
                mask_pos = mask_pos + 4'd1;
            end
            out_ready <= rdy;
        end
    end

    // Compare each result transfer with the oldest prediction; watch for a hang
    always @(posedge clk)
    begin : check_out
        frame_status_t act;
        frame_status_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                act = '{st_valid: store_valid, st_index: store_index, st_byte: store_byte,
                        done: frame_done, length: frame_length,
                        dropped: frame_dropped, ready: frame_ready};
                if (status_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result at %0t: %s", $time, status_str(act));
                end
                else
                begin
                    want = status_q.pop_front();
                    if (act.st_valid !== want.st_valid || act.st_index !== want.st_index ||
                        act.st_byte !== want.st_byte || act.done !== want.done ||
                        act.length !== want.length || act.dropped !== want.dropped ||
                        act.ready !== want.ready)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch at %0t: expected %s, got %s", $time,
                                     status_str(want), status_str(act));
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic write_start_byte(input logic [7:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mdl_start = v;
    endtask

    // Hold until every byte is sent and every result has come back
    task automatic wait_drained();
        do @(negedge clk);
        while (byte_jobs.size() != 0 || in_valid || status_q.size() != 0);
    endtask

    task automatic queue_byte(input logic [7:0] b);
        byte_jobs.push_back(dir_row(b, 1'b0, '0));
    endtask

    function automatic logic [7:0] payload_char();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CODE_CR || b == CODE_LF);
        return b;
    endfunction

    // Queue one frame: optional noise, start, payload, then a good or broken ending, or none
    task automatic queue_random_frame(output int counted);
        int n;
        int r;
        counted = 0;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
        queue_byte(mdl_start);
        r = $urandom_range(0, 19);
        if (r == 0)
            n = $urandom_range(62, 70);
        else if (r < 3)
            n = $urandom_range(0, 1);
        else
            n = $urandom_range(0, 12);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                queue_byte(mdl_start);
            else
                queue_byte(payload_char());
        end
        counted = n + 1;
        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            queue_byte(CODE_CR);
            queue_byte(CODE_LF);
            counted += 2;
        end
        else if (r < 7)
        begin
            queue_byte(CODE_LF);
            counted += 1;
        end
        else if (r == 7)
        begin
            queue_byte(CODE_CR);
            queue_byte(CODE_CR);
            queue_byte(CODE_LF);
            counted += 3;
        end
        else if (r == 8)
        begin
            queue_byte(CODE_CR);
            queue_byte(payload_char());
            counted += 2;
        end
    endtask

    initial
    begin : run_test
        int added;
        int phase_bytes;
        logic [7:0] sel;

        // Directed rows, start byte at its reset value of zero
        dir_tbl[0]  = dir_row(8'h41, 1'b1, status_of(0, 0, 8'h00, 0, 0, 0, 0));
        dir_tbl[1]  = dir_row(CODE_LF, 1'b1, status_of(0, 0, 8'h00, 0, 0, 0, 0));
        dir_tbl[2]  = dir_row(8'h00, 1'b1, status_of(0, 0, 8'h00, 0, 0, 0, 0));
        dir_tbl[3]  = dir_row(8'hFF, 1'b1, status_of(1, 0, 8'hFF, 0, 1, 0, 0));
        dir_tbl[4]  = dir_row(8'h00, 1'b1, status_of(1, 1, 8'h00, 0, 2, 0, 0));
        dir_tbl[5]  = dir_row(CODE_CR, 1'b1, status_of(0, 0, 8'h00, 0, 2, 0, 0));
        dir_tbl[6]  = dir_row(CODE_CR, 1'b1, status_of(0, 0, 8'h00, 0, 2, 0, 0));
        dir_tbl[7]  = dir_row(CODE_LF, 1'b1, status_of(0, 0, 8'h00, 1, 2, 0, 1));
        dir_tbl[8]  = dir_row(8'h00, 1'b1, status_of(0, 0, 8'h00, 0, 0, 0, 1));
        dir_tbl[9]  = dir_row(CODE_LF, 1'b0, '0);
        dir_tbl[10] = dir_row(8'h00, 1'b0, '0);
        dir_tbl[11] = dir_row(8'h80, 1'b0, '0);
        dir_tbl[12] = dir_row(8'h7F, 1'b0, '0);
        dir_tbl[13] = dir_row(CODE_CR, 1'b0, '0);
        dir_tbl[14] = dir_row(8'h55, 1'b1, status_of(0, 0, 8'h00, 0, 0, 1, 0));
        dir_tbl[15] = dir_row(CODE_CR, 1'b1, status_of(0, 0, 8'h00, 0, 0, 0, 0));
        dir_tbl[16] = dir_row(8'h00, 1'b0, '0);
        dir_tbl[17] = dir_row(CODE_LF, 1'b0, '0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_N; i++)
            byte_jobs.push_back(dir_tbl[i]);
        wait_drained();

        // Random frames under a sequence of start bytes
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p > 0)
            begin
                case (p)
                    1:       sel = 8'hFF;
                    2:       sel = CODE_CR;
                    3:       sel = CODE_LF;
                    4:       sel = 8'h00;
                    default: sel = 8'($urandom_range(0, 255));
                endcase
                write_start_byte(sel);
                @(negedge clk);
            end
            calm = (p == 2 || p == 5);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                queue_random_frame(added);
                phase_bytes += added;
            end
            wait_drained();
        end

        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && status_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
